/* rtl/core/utf8d_pkg.sv */
// ---------------------------------------------------------------------------
// utf8d_pkg
// types, constants and lead byte helpers shared by the decoder modules
// ---------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CP_W   = 31;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CP_W-1:0] REPLACEMENT = CP_W'(32'h0000_FFFD);

	// one decoded item as it leaves the block
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_error;
		logic            run_last;
		logic            stream_last;
	} result_t;

	// everything one input byte produces: one or two results
	typedef struct packed {
		result_t first;
		result_t second;
		logic    two;
	} pair_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	typedef enum logic [1:0] {
		LEAD_ASCII,
		LEAD_OPEN,
		LEAD_BAD
	} lead_kind_t;

	typedef struct packed {
		lead_kind_t kind;
		logic [2:0] cls;
		logic [4:0] bits;
	} lead_t;

	function automatic lead_t lead_decode(input logic [7:0] b);
		lead_t l;
		l.kind = LEAD_BAD;
		l.cls  = 3'd0;
		l.bits = 5'd0;
		if (b < 8'h80) begin
			l.kind = LEAD_ASCII;
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			l.kind = LEAD_OPEN;
			l.cls  = 3'd1;
			l.bits = b[4:0];
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			l.kind = LEAD_OPEN;
			l.cls  = 3'd2;
			l.bits = {1'b0, b[3:0]};
		end else if (b >= 8'hF0 && b <= 8'hF7) begin
			l.kind = LEAD_OPEN;
			l.cls  = 3'd3;
			l.bits = {2'b0, b[2:0]};
		end else if (b >= 8'hF8 && b <= 8'hFB) begin
			l.kind = LEAD_OPEN;
			l.cls  = 3'd4;
			l.bits = {3'b0, b[1:0]};
		end else if (b >= 8'hFC && b <= 8'hFD) begin
			l.kind = LEAD_OPEN;
			l.cls  = 3'd5;
			l.bits = {4'b0, b[0]};
		end
		return l;
	endfunction

	// smallest legal value for a sequence class
	function automatic logic [CP_W-1:0] min_for_class(input logic [2:0] cls);
		logic [CP_W-1:0] m;
		unique case (cls)
			3'd1:    m = CP_W'(32'h0000_0080);
			3'd2:    m = CP_W'(32'h0000_0800);
			3'd3:    m = CP_W'(32'h0001_0000);
			3'd4:    m = CP_W'(32'h0020_0000);
			3'd5:    m = CP_W'(32'h0400_0000);
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

/* rtl/core/utf8d_front.sv */
// ---------------------------------------------------------------------------
// utf8d_front
// accepts bytes, tracks the open sequence and builds the results per byte
// ---------------------------------------------------------------------------
module utf8d_front
	import utf8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  byte_in,
	input  logic        end_of_stream,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic        q_full,
	output logic        push,
	output pair_t       push_data
);

	logic [2:0]      rem_q;
	logic [CP_W-1:0] part_q;
	logic [2:0]      cls_q;

	logic [2:0]      rem_d;
	logic [CP_W-1:0] part_d;
	logic [2:0]      cls_d;

	lead_t           lead;
	logic            lead_emit;
	result_t         lead_res;
	result_t         err_res;
	result_t         r0;
	result_t         r1;
	logic            two;
	logic            any;
	logic            cont;
	logic [CP_W-1:0] shifted;
	logic [2:0]      rem_dec;
	logic            accept;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready;
	assign lead       = lead_decode(byte_in);
	assign cont       = (byte_in[7:6] == 2'b10);
	assign shifted    = {part_q[CP_W-7:0], byte_in[5:0]};
	assign rem_dec    = rem_q - 3'd1;

	always_comb begin
		err_res            = '0;
		err_res.code_point = REPLACEMENT;
		err_res.is_error   = 1'b1;

		lead_res  = err_res;
		lead_emit = 1'b1;
		unique case (lead.kind)
			LEAD_ASCII: begin
				lead_res            = '0;
				lead_res.code_point = CP_W'(byte_in);
			end
			LEAD_OPEN: lead_emit = end_of_stream;
			LEAD_BAD:  lead_emit = 1'b1;
			default:   lead_emit = 1'b1;
		endcase
	end

	always_comb begin
		r0     = '0;
		r1     = '0;
		two    = 1'b0;
		any    = 1'b0;
		rem_d  = rem_q;
		part_d = part_q;
		cls_d  = cls_q;

		if (rem_q != 3'd0 && cont) begin
			if (rem_dec == 3'd0) begin
				// sequence complete, check for overlong form
				any = 1'b1;
				if (shifted < min_for_class(cls_q)) begin
					r0 = err_res;
				end else begin
					r0.code_point = shifted;
				end
				rem_d  = 3'd0;
				part_d = '0;
				cls_d  = 3'd0;
			end else if (end_of_stream) begin
				any    = 1'b1;
				r0     = err_res;
				rem_d  = 3'd0;
				part_d = '0;
				cls_d  = 3'd0;
			end else begin
				rem_d  = rem_dec;
				part_d = shifted;
			end
		end else begin
			// broken sequence reports first, then byte is taken as a lead
			if (rem_q != 3'd0) begin
				any = 1'b1;
				r0  = err_res;
				if (lead_emit) begin
					r1  = lead_res;
					two = 1'b1;
				end
			end else if (lead_emit) begin
				any = 1'b1;
				r0  = lead_res;
			end
			if (lead.kind == LEAD_OPEN) begin
				rem_d  = lead.cls;
				cls_d  = lead.cls;
				part_d = CP_W'(lead.bits);
			end else begin
				rem_d  = 3'd0;
				part_d = '0;
				cls_d  = 3'd0;
			end
		end

		if (end_of_stream) begin
			rem_d  = 3'd0;
			part_d = '0;
			cls_d  = 3'd0;
		end

		if (two) begin
			r1.run_last    = 1'b1;
			r1.stream_last = end_of_stream;
		end else begin
			r0.run_last    = 1'b1;
			r0.stream_last = end_of_stream;
		end
	end

	assign push             = accept && any;
	assign push_data.first  = r0;
	assign push_data.second = r1;
	assign push_data.two    = two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 3'd0;
			part_q <= '0;
			cls_q  <= 3'd0;
		end else if (accept) begin
			rem_q  <= rem_d;
			part_q <= part_d;
			cls_q  <= cls_d;
		end
	end

endmodule

/* rtl/core/utf8d_queue.sv */
// ---------------------------------------------------------------------------
// utf8d_queue
// short fifo of per-byte result pairs between front and back
// ---------------------------------------------------------------------------
module utf8d_queue
	import utf8d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pair_t     push_data,
	input  logic      pop,
	output pair_t     head,
	output q_status_t status
);

	pair_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		if (p == QPTR_W'(QDEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + QPTR_W'(1);
		end
		return n;
	endfunction

	assign head         = slot_q[rd_q];
	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/core/utf8d_back.sv */
// ---------------------------------------------------------------------------
// utf8d_back
// unpacks result pairs and drives the registered output channel
// ---------------------------------------------------------------------------
module utf8d_back
	import utf8d_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  pair_t           head,
	input  logic            q_empty,
	output logic            pop,
	output logic [CP_W-1:0] code_point,
	output logic            is_error,
	output logic            run_last,
	output logic            stream_last,
	output logic            cp_valid,
	input  logic            cp_ready
);

	result_t    first_q;
	result_t    second_q;
	logic [1:0] cnt_q;
	logic       take;
	logic       need_load;

	assign cp_valid    = (cnt_q != 2'd0);
	assign take        = cp_valid && cp_ready;
	assign need_load   = (cnt_q == 2'd0) || (take && cnt_q == 2'd1);
	assign pop         = need_load && !q_empty;

	assign code_point  = first_q.code_point;
	assign is_error    = first_q.is_error;
	assign run_last    = first_q.run_last;
	assign stream_last = first_q.stream_last;

	always_ff @(posedge clk) begin
		if (pop) begin
			first_q  <= head.first;
			second_q <= head.second;
		end else if (take && cnt_q == 2'd2) begin
			first_q <= second_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (pop) begin
			cnt_q <= head.two ? 2'd2 : 2'd1;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* rtl/core/utf8_strict_stream_decoder.sv */
// ---------------------------------------------------------------------------
// utf8_strict_stream_decoder
// extended six-byte utf-8 decoder, one byte in, zero to two code points out
// ---------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  byte    | byte_valid byte_ready byte_in          | in
//          | end_of_stream                          |
//  cp      | cp_valid cp_ready code_point is_error  | out
//          | run_last stream_last                   |
//
//  one byte is taken per cycle; the front decodes it in the cycle it is taken
//  a result pair is registered in a queue slot, then in the output register
//  the output register drains one item per cycle while cp_ready is high, so
//  a byte's two results (broken sequence then a new lead) drain in turn
//  the two-entry queue decouples the sides; byte_ready drops only when full
//  arst_n clears the open sequence, the queue pointers and the output valid
// ---------------------------------------------------------------------------
module utf8_strict_stream_decoder
	import utf8d_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      byte_in,
	input  logic            end_of_stream,
	input  logic            byte_valid,
	output logic            byte_ready,
	output logic [CP_W-1:0] code_point,
	output logic            is_error,
	output logic            run_last,
	output logic            stream_last,
	output logic            cp_valid,
	input  logic            cp_ready
);

	// front to queue
	logic      push;
	pair_t     push_data;

	// queue to back
	pair_t     head;
	logic      pop;
	q_status_t q_status;

	// byte decode and sequence state
	utf8d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_in       (byte_in),
		.end_of_stream (end_of_stream),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.q_full        (q_status.full),
		.push          (push),
		.push_data     (push_data)
	);

	// one entry per byte that produced anything
	utf8d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// pair unpacking and output register
	utf8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_status.empty),
		.pop         (pop),
		.code_point  (code_point),
		.is_error    (is_error),
		.run_last    (run_last),
		.stream_last (stream_last),
		.cp_valid    (cp_valid),
		.cp_ready    (cp_ready)
	);

	// an error item always carries the replacement character
	a_err_is_replacement: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && is_error |-> code_point == REPLACEMENT)
		else $error("error item without replacement code point");

	// the final item of a stream also closes its byte
	a_stream_last_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && stream_last |-> run_last)
		else $error("stream_last without run_last");

	// queue occupancy stays within its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= QCNT_W'(QDEPTH))
		else $error("queue overflow");

	// a pop from an empty queue or a push into a full one never happens
	a_queue_guard: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_status.empty) && !(push && q_status.full))
		else $error("queue misuse");

endmodule
